/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the triangle geometry block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* src/teg_pkg.sv */
// ----------------------------------------------------------------------------
// teg_pkg
// shared types, constants and helpers of the triangle geometry block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package teg_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ValW   = 64;
  localparam int unsigned NumW   = 81;
  localparam int unsigned DenW   = 65;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [1:0] KIND_JAC   = 2'd0;
  localparam logic [1:0] KIND_EDGE0 = 2'd1;
  localparam logic [1:0] KIND_EDGE1 = 2'd2;
  localparam logic [1:0] KIND_EDGE2 = 2'd3;

  typedef struct packed {
    logic signed [DiffW-1:0] j00;
    logic signed [DiffW-1:0] j01;
    logic signed [DiffW-1:0] j10;
    logic signed [DiffW-1:0] j11;
  } jac_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // saturate a sign-magnitude value to signed Q32.32
  function automatic logic [ValW-1:0] sat_q32(input logic neg, input logic [NumW:0] mag);
    logic big;
    big = |mag[NumW:ValW-1];
    if (neg) begin
      sat_q32 = big ? {1'b1, {(ValW-1){1'b0}}} : (~mag[ValW-1:0] + 64'd1);
    end else begin
      sat_q32 = big ? {1'b0, {(ValW-1){1'b1}}} : mag[ValW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* src/triangle_element_geometry.sv */
// ----------------------------------------------------------------------------
// triangle_element_geometry
// jacobian, inverse, edge lengths and outward normals of a straight triangle
//
//   channel   handshake          payload
//   input     start / busy       x0_i y0_i x1_i y1_i x2_i y2_i
//   result    strobe_o (1 cycle) record_kind_o value_a_o..value_e_o
//                                clockwise_o degenerate_o last_o
//
// four result beats per triangle; most of its time goes to up to ten quotients
// on the shared 81-bit-quotient divider and to three 48-bit square roots
// a two-deep queue lets a new triangle be taken while the back works
// reset clears control state only; no clearing pass
// results cannot be held off; beats of one triangle are never adjacent
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_element_geometry (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [teg_pkg::CoordW-1:0]  x0_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]  y0_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]  x1_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]  y1_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]  x2_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]  y2_i,
  output logic                                    strobe_o,
  output logic [1:0]                              record_kind_o,
  output logic signed [teg_pkg::ValW-1:0]         value_a_o,
  output logic signed [teg_pkg::ValW-1:0]         value_b_o,
  output logic signed [teg_pkg::ValW-1:0]         value_c_o,
  output logic signed [teg_pkg::ValW-1:0]         value_d_o,
  output logic signed [teg_pkg::ValW-1:0]         value_e_o,
  output logic                                    clockwise_o,
  output logic                                    degenerate_o,
  output logic                                    last_o
);
  import teg_pkg::*;

  logic      q_push, q_pop;
  jac_t      q_in, q_out;
  q_status_t q_stat;

  teg_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .x0_i  (x0_i),
    .y0_i  (y0_i),
    .x1_i  (x1_i),
    .y1_i  (y1_i),
    .x2_i  (x2_i),
    .y2_i  (y2_i),
    .full_i(q_stat.full),
    .push_o(q_push),
    .data_o(q_in)
  );

  teg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .status_o(q_stat)
  );

  teg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_i       (q_out),
    .status_i     (q_stat),
    .pop_o        (q_pop),
    .strobe_o     (strobe_o),
    .record_kind_o(record_kind_o),
    .value_a_o    (value_a_o),
    .value_b_o    (value_b_o),
    .value_c_o    (value_c_o),
    .value_d_o    (value_d_o),
    .value_e_o    (value_e_o),
    .clockwise_o  (clockwise_o),
    .degenerate_o (degenerate_o),
    .last_o       (last_o)
  );

  `ASSERT_ALWAYS(a_strobe_gap, clk_i, rst_ni, strobe_o |=> !strobe_o, "result beats adjacent")
  `ASSERT_ALWAYS(a_last_kind, clk_i, rst_ni, strobe_o && last_o |-> record_kind_o == KIND_EDGE2, "last on wrong record")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_stat.full, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_stat.empty, "pop from empty queue")
  `ASSERT_ALWAYS(a_degen_inv, clk_i, rst_ni, strobe_o && degenerate_o && record_kind_o == KIND_JAC |-> value_b_o == 64'd0 && value_e_o == 64'd0, "degenerate inverse not zero")

endmodule

`default_nettype wire

/* src/teg_fifo.sv */
// ----------------------------------------------------------------------------
// teg_fifo
// short queue of jacobian beats between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teg_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire teg_pkg::jac_t data_i,
  input  wire logic          pop_i,
  output teg_pkg::jac_t      data_o,
  output teg_pkg::q_status_t status_o
);
  import teg_pkg::*;

  jac_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QCw-1:0] cnt_d, cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == QCw'(QDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

/* src/teg_front.sv */
// ----------------------------------------------------------------------------
// teg_front
// accepts vertex beats and forms the jacobian entries as vertex differences
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teg_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [teg_pkg::CoordW-1:0]   x0_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]   y0_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]   x1_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]   y1_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]   x2_i,
  input  wire logic signed [teg_pkg::CoordW-1:0]   y2_i,
  input  wire logic                                full_i,
  output logic                                     push_o,
  output teg_pkg::jac_t                            data_o
);
  import teg_pkg::*;

  logic fv_q;
  jac_t fd_q;
  logic accept;

  assign busy   = fv_q & full_i;
  assign accept = start & ~busy;
  assign push_o = fv_q & ~full_i;
  assign data_o = fd_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fd_q.j00 <= DiffW'(x1_i) - DiffW'(x0_i);
      fd_q.j01 <= DiffW'(x2_i) - DiffW'(x0_i);
      fd_q.j10 <= DiffW'(y1_i) - DiffW'(y0_i);
      fd_q.j11 <= DiffW'(y2_i) - DiffW'(y0_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (push_o) begin
      fv_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/teg_div.sv */
// ----------------------------------------------------------------------------
// teg_div
// restoring divider, one quotient bit a cycle, rounded and saturated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teg_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [teg_pkg::NumW-1:0]  num_i,
  input  wire logic [teg_pkg::DenW-1:0]  den_i,
  input  wire logic                      neg_i,
  output logic                           done_o,
  output logic [teg_pkg::ValW-1:0]       quot_o
);
  import teg_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);

  logic            run_q, fin_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q, quo_q;
  logic [DenW-1:0] den_q, rem_q;
  logic            neg_q;
  logic [DenW:0]   r2, diff;
  logic            ge, up;

  assign r2   = {rem_q, num_q[NumW-1]};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = (r2 >= {1'b0, den_q});
  assign up   = ({rem_q, 1'b0} >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      neg_q <= neg_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= ge ? diff[DenW-1:0] : r2[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fin_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(NumW - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = fin_q;
  assign quot_o = sat_q32(neg_q, {1'b0, quo_q} + {{NumW{1'b0}}, up});

endmodule

`default_nettype wire

/* src/teg_back.sv */
// ----------------------------------------------------------------------------
// teg_back
// sequencer: determinant, inverse, edge lengths and normals, record output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teg_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire teg_pkg::jac_t                  data_i,
  input  wire teg_pkg::q_status_t             status_i,
  output logic                                pop_o,
  output logic                                strobe_o,
  output logic [1:0]                          record_kind_o,
  output logic signed [teg_pkg::ValW-1:0]     value_a_o,
  output logic signed [teg_pkg::ValW-1:0]     value_b_o,
  output logic signed [teg_pkg::ValW-1:0]     value_c_o,
  output logic signed [teg_pkg::ValW-1:0]     value_d_o,
  output logic signed [teg_pkg::ValW-1:0]     value_e_o,
  output logic                                clockwise_o,
  output logic                                degenerate_o,
  output logic                                last_o
);
  import teg_pkg::*;

  localparam int unsigned RadW  = 96;
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned LenW  = RootW + 1;
  localparam int unsigned SremW = RootW + 3;
  localparam int unsigned ScntW = $clog2(RootW);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_DET   = 9'b000000100,
    S_DGO   = 9'b000001000,
    S_DWAIT = 9'b000010000,
    S_SGO   = 9'b000100000,
    S_SQRT  = 9'b001000000,
    S_SFIN  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } back_state_e;

  function automatic logic [CoordW-1:0] mag(input logic signed [DiffW:0] v);
    logic [DiffW:0] a;
    a = v[DiffW] ? (~v + 1'b1) : v;
    return a[CoordW-1:0];
  endfunction

  back_state_e state_d, state_q;

  logic signed [DiffW:0] j00, j01, j10, j11;
  jac_t                  jq_q;
  logic [3:0]            mcnt_q;
  logic [2*CoordW-1:0]   prod_q, mp_q, mq_q;
  logic [DenW-1:0]       s_q [3];
  logic [DenW-1:0]       dm_q;
  logic                  dneg_q, dz_q;
  logic [1:0]            rec_q, sub_q, ei;
  logic [ValW-1:0]       res_q [4];
  logic [LenW-1:0]       len_q, len_n;
  logic [RadW-1:0]       rad_q;
  logic [RootW-1:0]      root_q;
  logic [SremW-1:0]      srem_q, rsh, trial;
  logic [ScntW-1:0]      scnt_q;
  logic [CoordW-1:0]     ma, mb, dmag;
  logic signed [DiffW:0] nx, ny;
  logic                  np, nq, dneg_n, dz_n;
  logic [DenW-1:0]       dm_n;
  logic [NumW-1:0]       dnum;
  logic [DenW-1:0]       dden;
  logic                  dsign, dstart, ddone, bad;
  logic [ValW-1:0]       dquot;
  logic [DenW:0]         dround;

  assign j00 = (DiffW+1)'(jq_q.j00);
  assign j01 = (DiffW+1)'(jq_q.j01);
  assign j10 = (DiffW+1)'(jq_q.j10);
  assign j11 = (DiffW+1)'(jq_q.j11);

  // multiplier operands
  always_comb begin
    case (mcnt_q)
      4'd0:    begin ma = mag(j00);       mb = mag(j11);       end
      4'd1:    begin ma = mag(j01);       mb = mag(j10);       end
      4'd2:    begin ma = mag(j00 - j01); mb = mag(j00 - j01); end
      4'd3:    begin ma = mag(j10 - j11); mb = mag(j10 - j11); end
      4'd4:    begin ma = mag(j01);       mb = mag(j01);       end
      4'd5:    begin ma = mag(j11);       mb = mag(j11);       end
      4'd6:    begin ma = mag(j00);       mb = mag(j00);       end
      4'd7:    begin ma = mag(j10);       mb = mag(j10);       end
      default: begin ma = '0;             mb = '0;             end
    endcase
  end

  // determinant in sign-magnitude
  always_comb begin
    np = jq_q.j00[DiffW-1] ^ jq_q.j11[DiffW-1];
    nq = jq_q.j01[DiffW-1] ^ jq_q.j10[DiffW-1];
    if (np != nq) begin
      dm_n   = {1'b0, mp_q} + {1'b0, mq_q};
      dneg_n = np;
    end else if (mp_q >= mq_q) begin
      dm_n   = {1'b0, mp_q - mq_q};
      dneg_n = np;
    end else begin
      dm_n   = {1'b0, mq_q - mp_q};
      dneg_n = ~np;
    end
    dz_n = (dm_n == '0);
    if (dz_n) dneg_n = 1'b0;
  end

  assign ei = rec_q - 2'd1;

  always_comb begin
    case (rec_q)
      KIND_EDGE0: begin nx = j11 - j10; ny = j00 - j01; end
      KIND_EDGE1: begin nx = -j11;      ny = j01;       end
      KIND_EDGE2: begin nx = j10;       ny = -j00;      end
      default:    begin nx = '0;        ny = '0;        end
    endcase
  end

  // divider operand select
  always_comb begin
    dmag  = '0;
    dsign = 1'b0;
    if (rec_q == KIND_JAC) begin
      case (sub_q)
        2'd0:    begin dmag = mag(j11); dsign = jq_q.j11[DiffW-1] ^ dneg_q;  end
        2'd1:    begin dmag = mag(j01); dsign = ~jq_q.j01[DiffW-1] ^ dneg_q; end
        2'd2:    begin dmag = mag(j10); dsign = ~jq_q.j10[DiffW-1] ^ dneg_q; end
        default: begin dmag = mag(j00); dsign = jq_q.j00[DiffW-1] ^ dneg_q;  end
      endcase
      dnum = {dmag, 49'd0};
      dden = dm_q;
    end else begin
      if (sub_q == 2'd0) begin
        dmag  = mag(nx);
        dsign = nx[DiffW] ^ dneg_q;
      end else begin
        dmag  = mag(ny);
        dsign = ny[DiffW] ^ dneg_q;
      end
      dnum = {2'b00, dmag, 47'd0};
      dden = {{(DenW-LenW){1'b0}}, len_q};
    end
  end

  assign dstart = (state_q == S_DGO);

  teg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .num_i  (dnum),
    .den_i  (dden),
    .neg_i  (dsign),
    .done_o (ddone),
    .quot_o (dquot)
  );

  // root step
  assign rsh   = {srem_q[SremW-3:0], rad_q[RadW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign len_n = {1'b0, root_q} + {{RootW{1'b0}}, (srem_q > {3'b000, root_q})};
  assign bad   = dz_q | (len_q == '0);
  assign dround = {1'b0, dm_q} + 66'd2;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!status_i.empty) begin
          pop_o   = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL:   if (mcnt_q == 4'd8) state_d = S_DET;
      S_DET:   state_d = dz_n ? S_EMIT : S_DGO;
      S_DGO:   state_d = S_DWAIT;
      S_DWAIT: begin
        if (ddone) begin
          if ((rec_q == KIND_JAC && sub_q == 2'd3) || (rec_q != KIND_JAC && sub_q == 2'd1)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_DGO;
          end
        end
      end
      S_SGO:   state_d = S_SQRT;
      S_SQRT:  if (scnt_q == '0) state_d = S_SFIN;
      S_SFIN:  state_d = (dz_q || len_n == '0) ? S_EMIT : S_DGO;
      S_EMIT:  state_d = (rec_q == KIND_EDGE2) ? S_IDLE : S_SGO;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_o <= (state_q == S_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        jq_q   <= data_i;
        mcnt_q <= '0;
        rec_q  <= KIND_JAC;
        sub_q  <= '0;
      end
      S_MUL: begin
        prod_q <= ma * mb;
        mcnt_q <= mcnt_q + 4'd1;
        case (mcnt_q)
          4'd1:    mp_q   <= prod_q;
          4'd2:    mq_q   <= prod_q;
          4'd3:    s_q[0] <= {1'b0, prod_q};
          4'd4:    s_q[0] <= s_q[0] + {1'b0, prod_q};
          4'd5:    s_q[1] <= {1'b0, prod_q};
          4'd6:    s_q[1] <= s_q[1] + {1'b0, prod_q};
          4'd7:    s_q[2] <= {1'b0, prod_q};
          4'd8:    s_q[2] <= s_q[2] + {1'b0, prod_q};
          default: ;
        endcase
      end
      S_DET: begin
        dm_q   <= dm_n;
        dneg_q <= dneg_n;
        dz_q   <= dz_n;
      end
      S_DWAIT: begin
        if (ddone) begin
          res_q[sub_q] <= dquot;
          sub_q        <= sub_q + 2'd1;
        end
      end
      S_SGO: begin
        rad_q  <= {1'b0, s_q[ei], 30'd0};
        root_q <= '0;
        srem_q <= '0;
        scnt_q <= ScntW'(RootW - 1);
      end
      S_SQRT: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        scnt_q <= scnt_q - 1'b1;
        if (rsh >= trial) begin
          srem_q <= rsh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          srem_q <= rsh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      S_SFIN: begin
        len_q <= len_n;
        sub_q <= '0;
      end
      S_EMIT: begin
        record_kind_o <= rec_q;
        clockwise_o   <= dneg_q;
        last_o        <= (rec_q == KIND_EDGE2);
        value_d_o     <= '0;
        value_e_o     <= '0;
        if (rec_q == KIND_JAC) begin
          value_a_o    <= sat_q32(dneg_q, {{(NumW+1-ValW){1'b0}}, dround[DenW:2]});
          value_b_o    <= dz_q ? '0 : res_q[0];
          value_c_o    <= dz_q ? '0 : res_q[1];
          value_d_o    <= dz_q ? '0 : res_q[2];
          value_e_o    <= dz_q ? '0 : res_q[3];
          degenerate_o <= dz_q;
        end else begin
          value_a_o    <= {{(ValW-LenW){1'b0}}, len_q};
          value_b_o    <= bad ? '0 : res_q[0];
          value_c_o    <= bad ? '0 : res_q[1];
          degenerate_o <= bad;
        end
        rec_q <= rec_q + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
